FILE: rtl/prefix_code_decoder_defines.svh
// assertion helpers for the prefix code decoder
`ifndef PREFIX_CODE_DECODER_DEFINES_SVH
`define PREFIX_CODE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define PCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PCD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PCD_ASSERT(lbl, prop, msg)
`define PCD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/pcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int MAX_CODE_LEN  = 16;
  localparam int LEN_W         = $clog2(MAX_CODE_LEN + 1);
  localparam int BYTE_TOP_BIT  = 7;
  localparam int CODE_W        = 16;
  localparam int CLEN_W        = 5;
  localparam int SYM_W         = 21;
  localparam int CMP_W         = 32;
  localparam int ENTRY_W       = CODE_W + CLEN_W + SYM_W;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_FINAL  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        entry_index;
    logic [CODE_W-1:0] code_bits;
    logic [CLEN_W-1:0] code_length;
    logic [SYM_W-1:0]  code_symbol;
    logic [7:0]        data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
    logic             overflow_error;
  } out_beat_t;

  typedef struct packed {
    logic write_entry;
    logic load_byte;
    logic shift_bit;
    logic scan_run;
    logic take_result;
    logic push_last;
    logic end_item;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bits_left_zero;
    logic scan_done;
    logic hit;
    logic overflow;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/pcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/pcd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pcd_datapath import pcd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_beat_t  in_i,
  input  wire ctrl_cmd_t cmd_i,
  output dp_stat_t       stat_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_o,
  output logic           out_valid_o
);

  logic [7:0]              byte_q;
  logic [3:0]              bits_q;
  logic                    final_q;
  logic [MAX_CODE_LEN-1:0] acc_q;
  logic [LEN_W-1:0]        alen_q;
  logic [ADDR_W:0]         scan_q;
  logic                    cmp_v_q;
  logic                    rvalid_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [SYM_W-1:0]        res_sym_q;
  logic                    res_err_q;
  logic [SYM_W-1:0]        pend_sym_q;
  logic                    pend_err_q;
  logic                    pend_valid_q;
  out_beat_t               out_q;
  logic                    out_valid_q;

  logic [ADDR_W-1:0]  waddr;
  logic               in_range;
  logic [ADDR_W-1:0]  raddr;
  logic               scan_more;
  logic [ENTRY_W-1:0] rdata;
  logic [CODE_W-1:0]  rcode;
  logic [CLEN_W-1:0]  rlen;
  logic [SYM_W-1:0]   rsym;
  logic [CMP_W:0]     mask_w;
  logic               hit;
  logic [2:0]         stop;
  logic [3:0]         nbits;
  logic               out_free;

  assign waddr     = ADDR_W'(in_i.entry_index);
  assign in_range  = 32'(in_i.entry_index) < TABLE_ENTRIES;
  assign raddr     = scan_q[ADDR_W-1:0];
  assign scan_more = scan_q < (ADDR_W + 1)'(TABLE_ENTRIES);

  pcd_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_entry && in_range),
    .waddr_i (waddr),
    .wdata_i ({in_i.code_bits, in_i.code_length, in_i.code_symbol}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign {rcode, rlen, rsym} = rdata;
  assign mask_w = ((CMP_W + 1)'(1) << alen_q) - (CMP_W + 1)'(1);
  assign hit = cmp_v_q && rvalid_q && (32'(rlen) == 32'(alen_q)) &&
               ((CMP_W'(rcode) & mask_w[CMP_W-1:0]) == CMP_W'(acc_q));

  // lowest set bit of a final byte is the stop bit
  always_comb begin
    stop = 3'd0;
    for (int b = BYTE_TOP_BIT; b >= 0; b--) begin
      if (in_i.data_byte[b]) begin
        stop = 3'(b);
      end
    end
    nbits = 4'(BYTE_TOP_BIT) - {1'b0, stop};
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q       <= '0;
      final_q      <= 1'b0;
      acc_q        <= '0;
      alen_q       <= '0;
      scan_q       <= '0;
      cmp_v_q      <= 1'b0;
      rvalid_q     <= 1'b0;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.write_entry && in_range) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.load_byte) begin
        final_q <= (in_i.mode == MODE_FINAL);
        bits_q  <= (in_i.mode == MODE_FINAL) ? nbits : 4'd8;
      end
      if (cmd_i.shift_bit) begin
        acc_q   <= {acc_q[MAX_CODE_LEN-2:0], byte_q[7]};
        alen_q  <= alen_q + LEN_W'(1);
        bits_q  <= bits_q - 4'd1;
        scan_q  <= '0;
        cmp_v_q <= 1'b0;
      end
      if (cmd_i.scan_run) begin
        cmp_v_q  <= scan_more;
        rvalid_q <= valid_q[raddr];
        if (scan_more) begin
          scan_q <= scan_q + (ADDR_W + 1)'(1);
        end
      end
      // output register loads from the pending slot, else drains on accept
      if ((cmd_i.take_result && pend_valid_q) || cmd_i.push_last) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.take_result) begin
        pend_valid_q <= 1'b1;
        acc_q        <= '0;
        alen_q       <= '0;
      end
      if (cmd_i.push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.end_item && final_q) begin
        acc_q  <= '0;
        alen_q <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= in_i.data_byte;
    end
    if (cmd_i.shift_bit) begin
      byte_q <= {byte_q[6:0], 1'b0};
    end
    if (cmd_i.scan_run) begin
      res_sym_q <= hit ? rsym : '0;
      res_err_q <= !hit;
    end
    if (cmd_i.take_result) begin
      if (pend_valid_q) begin
        out_q <= '{symbol: pend_sym_q, last_of_run: 1'b0, overflow_error: pend_err_q};
      end
      pend_sym_q <= res_sym_q;
      pend_err_q <= res_err_q;
    end
    if (cmd_i.push_last) begin
      out_q <= '{symbol: pend_sym_q, last_of_run: 1'b1, overflow_error: pend_err_q};
    end
  end

  assign stat_o.bits_left_zero = (bits_q == 4'd0);
  assign stat_o.scan_done      = !cmp_v_q && !scan_more;
  assign stat_o.hit            = hit;
  assign stat_o.overflow       = 32'(alen_q) >= MAX_CODE_LEN;
  assign stat_o.pend_valid     = pend_valid_q;
  assign stat_o.out_free       = out_free;

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/pcd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pcd_ctrl import pcd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_mode_i,
  input  wire dp_stat_t   stat_i,
  output ctrl_cmd_t       cmd_o,
  output logic            in_stall_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_SCAN,
    ST_RESULT,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_mode_i)
            MODE_LOAD: cmd_o.write_entry = 1'b1;
            MODE_DATA, MODE_FINAL: begin
              cmd_o.load_byte = 1'b1;
              state_d = ST_NEXT;
            end
            default: ;
          endcase
        end
      end
      ST_NEXT: begin
        if (stat_i.bits_left_zero) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.shift_bit = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.hit) begin
          state_d = ST_RESULT;
        end else if (stat_i.scan_done) begin
          state_d = stat_i.overflow ? ST_RESULT : ST_NEXT;
        end
      end
      ST_RESULT: begin
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.take_result = 1'b1;
          state_d = ST_NEXT;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_valid) begin
          cmd_o.end_item = 1'b1;
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.push_last = 1'b1;
          cmd_o.end_item  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

FILE: rtl/prefix_code_decoder.sv
// prefix code decoder: input beats on in_i (valid/stall), results on out_o.
// a load beat (mode 0) writes one table slot and gives no result.
// a data beat (mode 1) or final beat (mode 2) is decoded msb first, one bit at
// a time; each bit scans the code table through one ram read port, one entry
// a cycle, stopping at the first (lowest index) hit.
// each bit runs a table scan, cut short when a hit comes, plus a result
// handoff after a hit or an overflow bit; a byte holds in_stall_o high until
// all of its bits are scanned and its results handed off.
// results leave through a one-deep pending stage and an output register, so
// last_of_run can be marked on the final result of each beat; up to eight
// results per beat, each one beat on out_o.
// in_stall_o is high while a byte is being decoded; loads take back to back.
// when out_stall_i holds a result, the decoder keeps scanning until the
// pending slot is full and a further result is ready, then waits.
// after a final beat the partial code is dropped.
// reset clears all table valid bits, the accumulator and all handshake state;
// table contents stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "prefix_code_decoder_defines.svh"
module prefix_code_decoder import pcd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_beat_t in_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_beat_t     out_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      byte_taken;

  // sequencer: one bit shift, table scan, result handoff
  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_i.mode),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // table ram, accumulator, pending result and output register
  pcd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .out_valid_o (out_valid_o)
  );

  // a data or final beat accepted this cycle
  assign byte_taken = in_valid_i && !in_stall_o && (in_i.mode inside {MODE_DATA, MODE_FINAL});

  // a new result may only overwrite the pending slot once it can move on
  `PCD_ASSERT(a_take_room, cmd.take_result |-> (!stat.pend_valid || stat.out_free), "result lost")
  // the last result of a beat goes out only from a filled pending slot
  `PCD_ASSERT(a_push_last, cmd.push_last |-> (stat.pend_valid && stat.out_free), "bad flush")
  // a data or final beat blocks the input while it is decoded
  `PCD_ASSERT(a_busy, byte_taken |=> in_stall_o, "no stall")

endmodule
`default_nettype wire
